// ===== rtl/lgs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_pkg
// Types and constants shared by the life grid step unit.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int CFG_DW = 8;

    typedef enum logic [1:0] {
        ACT_TOGGLE  = 2'd0,
        ACT_ADVANCE = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] cell_x;
        logic [5:0] cell_y;
    } in_t;

    typedef struct packed {
        logic cell_value;
        logic out_of_range;
    } out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_ITEM_RD,
        ST_ITEM_DO,
        ST_GEN_INIT,
        ST_GEN_LOAD,
        ST_GEN_RD,
        ST_GEN_WR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic take;
        logic clr;
        logic rd_item;
        logic do_item;
        logic gen_init;
        logic gen_load;
        logic gen_rd;
        logic gen_wr;
        logic emit;
    } cmd_t;

    typedef struct packed {
        action_t act;
        logic    oor;
        logic    empty;
        logic    row_last;
        logic    clr_last;
        logic    out_free;
    } stat_t;

endpackage
`default_nettype wire

// ===== rtl/lgs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lgs_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/lgs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_ctrl
// Sequencer for clearing, cell access and generation sweeps.
// ----------------------------------------------------------------------------
module lgs_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire lgs_pkg::stat_t stat,
    output lgs_pkg::cmd_t      cmd
);

    lgs_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lgs_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lgs_pkg::ST_CLEAR: begin
                if (stat.clr_last) state_next = lgs_pkg::ST_IDLE;
            end
            lgs_pkg::ST_IDLE: begin
                if (s_valid) state_next = lgs_pkg::ST_DISPATCH;
            end
            lgs_pkg::ST_DISPATCH: begin
                if (stat.act == lgs_pkg::ACT_ADVANCE) begin
                    state_next = stat.empty ? lgs_pkg::ST_RESP : lgs_pkg::ST_GEN_INIT;
                end else if ((stat.act == lgs_pkg::ACT_TOGGLE ||
                              stat.act == lgs_pkg::ACT_READ) && !stat.oor) begin
                    state_next = lgs_pkg::ST_ITEM_RD;
                end else begin
                    state_next = lgs_pkg::ST_RESP;
                end
            end
            lgs_pkg::ST_ITEM_RD:  state_next = lgs_pkg::ST_ITEM_DO;
            lgs_pkg::ST_ITEM_DO:  state_next = lgs_pkg::ST_RESP;
            lgs_pkg::ST_GEN_INIT: state_next = lgs_pkg::ST_GEN_LOAD;
            lgs_pkg::ST_GEN_LOAD: state_next = lgs_pkg::ST_GEN_RD;
            lgs_pkg::ST_GEN_RD:   state_next = lgs_pkg::ST_GEN_WR;
            lgs_pkg::ST_GEN_WR: begin
                state_next = stat.row_last ? lgs_pkg::ST_RESP : lgs_pkg::ST_GEN_RD;
            end
            lgs_pkg::ST_RESP: begin
                if (stat.out_free) state_next = lgs_pkg::ST_IDLE;
            end
            default: state_next = lgs_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            lgs_pkg::ST_CLEAR:    cmd.clr = 1'b1;
            lgs_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            lgs_pkg::ST_DISPATCH: ;
            lgs_pkg::ST_ITEM_RD:  cmd.rd_item  = 1'b1;
            lgs_pkg::ST_ITEM_DO:  cmd.do_item  = 1'b1;
            lgs_pkg::ST_GEN_INIT: cmd.gen_init = 1'b1;
            lgs_pkg::ST_GEN_LOAD: cmd.gen_load = 1'b1;
            lgs_pkg::ST_GEN_RD:   cmd.gen_rd   = 1'b1;
            lgs_pkg::ST_GEN_WR:   cmd.gen_wr   = 1'b1;
            lgs_pkg::ST_RESP:     cmd.emit     = stat.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/lgs_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_dpath
// Row memory, row window registers, neighbor logic and result register.
// ----------------------------------------------------------------------------
module lgs_dpath #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire lgs_pkg::cmd_t                cmd,
    output lgs_pkg::stat_t                    stat,
    input  wire lgs_pkg::in_t                 s_data,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_addr,
    input  wire logic [lgs_pkg::CFG_DW-1:0]   cfg_wdata,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output lgs_pkg::out_t                     m_data
);

    localparam int AW  = $clog2(MAX_HEIGHT);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int WUW = $clog2(MAX_WIDTH + 1);
    localparam int HUW = $clog2(MAX_HEIGHT + 1);

    logic [7:0]           width_reg;
    logic [6:0]           height_reg;
    logic [1:0]           act_reg;
    logic [6:0]           x_reg;
    logic [5:0]           y_reg;
    logic [AW-1:0]        row_reg;
    logic [MAX_WIDTH-1:0] prev_reg;
    logic [MAX_WIDTH-1:0] cur_reg;
    logic                 val_reg;
    logic                 m_valid_reg;
    lgs_pkg::out_t        m_data_reg;

    logic [WUW-1:0]       w_used;
    logic [HUW-1:0]       h_used;
    logic [MAX_WIDTH-1:0] col_mask;
    logic [MAX_WIDTH-1:0] below;
    logic [MAX_WIDTH-1:0] new_row;
    logic                 below_ok;
    logic                 item_oor;
    logic                 is_cell_act;
    logic [XW-1:0]        x_idx;
    logic [AW-1:0]        y_idx;
    logic [AW-1:0]        row_inc;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [MAX_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [MAX_WIDTH-1:0] ram_rdata;

    assign w_used = (int'(width_reg) > MAX_WIDTH) ? WUW'(MAX_WIDTH) : WUW'(width_reg);
    assign h_used = (int'(height_reg) > MAX_HEIGHT) ? HUW'(MAX_HEIGHT) : HUW'(height_reg);

    assign x_idx   = XW'(x_reg);
    assign y_idx   = AW'(y_reg);
    assign row_inc = AW'(int'(row_reg) + 1);

    assign item_oor    = (int'(x_reg) >= int'(w_used)) || (int'(y_reg) >= int'(h_used));
    assign is_cell_act = (act_reg == lgs_pkg::ACT_TOGGLE) || (act_reg == lgs_pkg::ACT_READ);
    assign below_ok    = (int'(row_reg) + 1) < int'(h_used);

    always_comb begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            col_mask[i] = i < int'(w_used);
        end
    end

    assign below = below_ok ? (ram_rdata & col_mask) : '0;

    // b3/s23 on the window of three rows, columns outside count as dead
    always_comb begin
        logic [MAX_WIDTH+1:0] up_p;
        logic [MAX_WIDTH+1:0] mid_p;
        logic [MAX_WIDTH+1:0] dn_p;
        logic [3:0]           n;
        up_p  = {1'b0, prev_reg, 1'b0};
        mid_p = {1'b0, cur_reg & col_mask, 1'b0};
        dn_p  = {1'b0, below, 1'b0};
        for (int i = 0; i < MAX_WIDTH; i++) begin
            n = 4'(up_p[i]) + 4'(up_p[i+1]) + 4'(up_p[i+2]) + 4'(mid_p[i])
              + 4'(mid_p[i+2]) + 4'(dn_p[i]) + 4'(dn_p[i+1]) + 4'(dn_p[i+2]);
            new_row[i] = (n == lgs_pkg::BIRTH_COUNT) ||
                         ((n == lgs_pkg::SURVIVE_COUNT) && mid_p[i+1]);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = row_reg;
        ram_wdata = '0;
        if (cmd.clr) begin
            ram_we = 1'b1;
        end else if (cmd.do_item && act_reg == lgs_pkg::ACT_TOGGLE) begin
            ram_we    = 1'b1;
            ram_waddr = y_idx;
            ram_wdata = ram_rdata ^ (MAX_WIDTH'(1) << x_idx);
        end else if (cmd.gen_wr) begin
            ram_we    = 1'b1;
            // unused columns keep their stored bits
            ram_wdata = (new_row & col_mask) | (cur_reg & ~col_mask);
        end
    end

    always_comb begin
        ram_raddr = '0;
        if (cmd.rd_item) begin
            ram_raddr = y_idx;
        end else if (cmd.gen_rd) begin
            ram_raddr = row_inc;
        end
    end

    lgs_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= 8'd128;
            height_reg  <= 7'd64;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == lgs_pkg::REG_GRID_WIDTH) begin
                    width_reg <= cfg_wdata;
                end else begin
                    height_reg <= cfg_wdata[6:0];
                end
            end
            if (cmd.clr || cmd.gen_wr) begin
                row_reg <= row_inc;
            end else if (cmd.gen_init) begin
                row_reg <= '0;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            act_reg <= s_data.action;
            x_reg   <= s_data.cell_x;
            y_reg   <= s_data.cell_y;
            val_reg <= 1'b0;
        end
        if (cmd.do_item) begin
            val_reg <= ram_rdata[x_idx] ^ (act_reg == lgs_pkg::ACT_TOGGLE);
        end
        if (cmd.gen_load) begin
            prev_reg <= '0;
            cur_reg  <= ram_rdata;
        end
        if (cmd.gen_wr) begin
            prev_reg <= cur_reg & col_mask;
            cur_reg  <= ram_rdata;
        end
        if (cmd.emit) begin
            m_data_reg.cell_value   <= val_reg;
            m_data_reg.out_of_range <= is_cell_act && item_oor;
        end
    end

    assign stat.act      = lgs_pkg::action_t'(act_reg);
    assign stat.oor      = item_oor;
    assign stat.empty    = (w_used == '0) || (h_used == '0);
    assign stat.row_last = (int'(row_reg) + 1) == int'(h_used);
    assign stat.clr_last = int'(row_reg) == MAX_HEIGHT - 1;
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ===== rtl/life_grid_step_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// life_grid_step_unit
// Game of life grid (B3/S23, no wrap) with toggle, read and step actions.
// ----------------------------------------------------------------------------
// Input words arrive on s_valid/s_ready/s_data: toggle a cell, read a cell,
// or advance all used cells one generation. Each word yields exactly one
// result word on m_valid/m_ready/m_data (cell value, out of range flag).
// Used width and height are set through cfg_wr_en/cfg_addr/cfg_wdata while
// idle (the user's duty; the block does not enforce it); values above the storage size saturate.
// The grid is held as MAX_HEIGHT rows of MAX_WIDTH bits in one RAM with a
// registered read, so a row is read and written per step.
// A toggle or read passes through the dispatch, row read and update states
// before its result; an out of range or unused word goes from dispatch to
// the result. A generation loads the first row, then for each used row reads
// the row below and writes the new row through the single RAM. One word is in
// work at a time; the next is accepted once the result sits in the output register.
// After reset a clearing pass writes zero to every row with s_ready low. A
// stalled receiver holds the result in the output register; the unit holds
// its next result back until that register is free.
// ----------------------------------------------------------------------------
module life_grid_step_unit #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire lgs_pkg::in_t                s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output lgs_pkg::out_t                    m_data,
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_addr,
    input  wire logic [lgs_pkg::CFG_DW-1:0]  cfg_wdata
);

    lgs_pkg::cmd_t  cmd;
    lgs_pkg::stat_t stat;

    lgs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lgs_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

// ===== rtl/lgs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_checker
// Port level checks for the life grid step unit.
// ----------------------------------------------------------------------------
module lgs_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire lgs_pkg::out_t m_data
);

    // result held while receiver stalls
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed under stall");

    // clearing pass keeps input closed right after reset
    a_clear_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input open during clearing pass");

    // one word in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while busy");

    // a flagged coordinate never reports a live cell
    a_flag_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.cell_value && m_data.out_of_range))
        else $error("live value with out of range flag");

endmodule

bind life_grid_step_unit lgs_checker u_lgs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

// ===== dv/life_grid_step_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// life_grid_step_checker
// Watches both channels of the life grid step unit, keeps its own copy of the
// grid and the used size, predicts each result word and compares it.
// ----------------------------------------------------------------------------
module life_grid_step_checker (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_ready,
    input  wire lgs_pkg::in_t     s_data,
    input  wire logic             m_valid,
    input  wire logic             m_ready,
    input  wire lgs_pkg::out_t    m_data,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_addr,
    input  wire logic [7:0]       cfg_wdata,
    output int                    fail_count,
    output int                    pending_count
);

    localparam int COLS = 128;
    localparam int ROWS = 64;

    bit   life_cells [ROWS][COLS];
    bit   next_cells [ROWS][COLS];
    bit [7:0] width_reg;
    bit [6:0] height_reg;
    lgs_pkg::out_t expected_words[$];

    function automatic int used_cols();
        return (width_reg > COLS) ? COLS : int'(width_reg);
    endfunction

    function automatic int used_rows();
        return (height_reg > ROWS) ? ROWS : int'(height_reg);
    endfunction

    function automatic void step_generation();
        int w, h, n;
        w = used_cols();
        h = used_rows();
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                n = 0;
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dx = -1; dx <= 1; dx++) begin
                        if ((dx != 0 || dy != 0) && x + dx >= 0 && y + dy >= 0 &&
                            x + dx < w && y + dy < h)
                            n += life_cells[y + dy][x + dx];
                    end
                end
                next_cells[y][x] = (n == 3) ? 1'b1 : (n == 2) ? life_cells[y][x] : 1'b0;
            end
        end
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                life_cells[y][x] = next_cells[y][x];
    endfunction

    function automatic lgs_pkg::out_t apply_word(lgs_pkg::in_t word);
        lgs_pkg::out_t r;
        r = '0;
        case (lgs_pkg::action_t'(word.action))
            lgs_pkg::ACT_ADVANCE: step_generation();
            lgs_pkg::ACT_TOGGLE, lgs_pkg::ACT_READ: begin
                if (word.cell_x >= used_cols() || word.cell_y >= used_rows()) begin
                    r.out_of_range = 1'b1;
                end else begin
                    if (lgs_pkg::action_t'(word.action) == lgs_pkg::ACT_TOGGLE)
                        life_cells[word.cell_y][word.cell_x] ^= 1'b1;
                    r.cell_value = life_cells[word.cell_y][word.cell_x];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    assign pending_count = expected_words.size();

    always @(posedge aclk) begin
        lgs_pkg::out_t want;
        if (!aresetn) begin
            foreach (life_cells[y, x]) life_cells[y][x] = 1'b0;
            width_reg  = 8'd128;
            height_reg = 7'd64;
            expected_words.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == lgs_pkg::REG_GRID_WIDTH) width_reg = cfg_wdata;
                else height_reg = cfg_wdata[6:0];
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word %b", $time, m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (want.cell_value !== m_data.cell_value ||
                        want.out_of_range !== m_data.out_of_range) begin
                        $display("%0t: mismatch expected value=%b oor=%b actual value=%b oor=%b",
                                 $time, want.cell_value, want.out_of_range,
                                 m_data.cell_value, m_data.out_of_range);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_words.push_back(apply_word(s_data));
        end
    end
endmodule
`default_nettype wire

// ===== dv/tb_life_grid_step_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_life_grid_step_unit
// Drives toggle, read, generation and unused code words into the life grid step
// unit under several grid sizes with random gaps and stalls; the checker judges results.
// ----------------------------------------------------------------------------
module tb_life_grid_step_unit;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    lgs_pkg::in_t  s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    lgs_pkg::out_t m_data;
    logic          cfg_wr_en = 1'b0;
    logic          cfg_addr = lgs_pkg::REG_GRID_WIDTH;
    logic [7:0]    cfg_wdata = '0;
    int            fail_count;
    int            pending_count;
    bit            calm_tail = 1'b0;
    int            word_total = 0;
    int            step_total = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    life_grid_step_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    life_grid_step_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // receiver stalls in random bursts
    initial begin
        int hold;
        forever begin
            @(negedge aclk);
            if (!calm_tail && $urandom_range(0, 3) == 0) begin
                hold = $urandom_range(1, 3);
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // valid drops at the falling edge after accept; the next word rises at a later falling edge
    task automatic send_word(input logic [1:0] act, input logic [6:0] x, input logic [5:0] y);
        if (!calm_tail && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        @(negedge aclk);
        s_data  <= '{action: act, cell_x: x, cell_y: y};
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 1'b0;
        word_total++;
        if (act == lgs_pkg::ACT_ADVANCE) step_total++;
    endtask

    task automatic write_size(input logic [7:0] w, input logic [7:0] h);
        while (pending_count != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= lgs_pkg::REG_GRID_WIDTH;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_addr  <= lgs_pkg::REG_GRID_HEIGHT;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // random word mostly inside the used area so patterns evolve
    task automatic random_word(input int w, input int h);
        logic [1:0] act;
        logic [6:0] x;
        logic [5:0] y;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 10) act = lgs_pkg::ACT_TOGGLE;
        else if (pick < 14) act = lgs_pkg::ACT_READ;
        else if (pick < 18) act = lgs_pkg::ACT_ADVANCE;
        else act = logic'(pick[0]) ? lgs_pkg::ACT_NONE : lgs_pkg::ACT_READ;
        if ($urandom_range(0, 7) == 0 || w == 0 || h == 0) begin
            x = 7'($urandom);
            y = 6'($urandom);
        end else begin
            x = 7'($urandom_range(0, (w > 128 ? 128 : w) - 1));
            y = 6'($urandom_range(0, (h > 64 ? 64 : h) - 1));
        end
        send_word(act, x, y);
    endtask

    initial begin
        int sizes[6][2] = '{'{8, 6}, '{255, 127}, '{0, 5}, '{1, 1}, '{3, 3}, '{128, 64}};
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // blinker and a three-cell corner pattern on full grid, corners, out of range, unused code
        send_word(lgs_pkg::ACT_TOGGLE, 7'd1, 6'd0);
        send_word(lgs_pkg::ACT_TOGGLE, 7'd1, 6'd1);
        send_word(lgs_pkg::ACT_TOGGLE, 7'd1, 6'd2);
        send_word(lgs_pkg::ACT_ADVANCE, 7'd0, 6'd0);
        send_word(lgs_pkg::ACT_READ, 7'd0, 6'd1);
        send_word(lgs_pkg::ACT_READ, 7'd1, 6'd1);
        send_word(lgs_pkg::ACT_READ, 7'd1, 6'd0);
        send_word(lgs_pkg::ACT_TOGGLE, 7'd127, 6'd63);
        send_word(lgs_pkg::ACT_TOGGLE, 7'd126, 6'd63);
        send_word(lgs_pkg::ACT_TOGGLE, 7'd127, 6'd62);
        send_word(lgs_pkg::ACT_ADVANCE, 7'h7f, 6'h3f);
        send_word(lgs_pkg::ACT_READ, 7'd126, 6'd62);
        send_word(lgs_pkg::ACT_NONE, 7'h7f, 6'h3f);
        send_word(lgs_pkg::ACT_TOGGLE, 7'd0, 6'd0);
        send_word(lgs_pkg::ACT_READ, 7'd0, 6'd0);
        write_size(8'd4, 8'd3);
        send_word(lgs_pkg::ACT_READ, 7'd4, 6'd0);
        send_word(lgs_pkg::ACT_TOGGLE, 7'd0, 6'd3);
        send_word(lgs_pkg::ACT_ADVANCE, 7'd0, 6'd0);
        send_word(lgs_pkg::ACT_READ, 7'd1, 6'd1);
        write_size(8'd128, 8'd64);
        send_word(lgs_pkg::ACT_READ, 7'd127, 6'd63);

        for (int p = 0; p < 6; p++) begin
            write_size(sizes[p][0][7:0], sizes[p][1][7:0]);
            if (p == 5) calm_tail = 1'b1;
            repeat (16) random_word(sizes[p][0], sizes[p][1]);
        end

        fork
            while (pending_count != 0) @(negedge aclk);
            begin
                repeat (20000) @(negedge aclk);
            end
        join_any
        disable fork;
        repeat (200) @(negedge aclk);
        $display("covered %0d words, %0d generation steps, six grid sizes from empty to oversized",
                 word_total, step_total);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_life_grid_step_unit: clean");
        else
            $display("tb_life_grid_step_unit: errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_life_grid_step_unit: errors");
        $finish;
    end
endmodule
`default_nettype wire
